### src/gbd_pkg.sv
package gbd_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_BFS   = 2'd2,
        FUNC_DFS   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int unsigned LINK_W   = 10;
    localparam logic [LINK_W-1:0] NIL_LINK = 10'd1023;
    localparam int unsigned VERT_W   = 6;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_ADD_A,
        S_ADD_B,
        S_RESULT,
        S_VCLR,
        S_B_POP,
        S_B_HEAD,
        S_B_WALK,
        S_B_RD,
        S_B_CHK,
        S_D_TOP,
        S_D_CHK,
        S_D_RD,
        S_D_EVAL,
        S_D_PUSH,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clr_heads;
        logic prepend_a;
        logic prepend_b;
        logic vclr;
        logic b_init;
        logic b_pop;
        logic b_head;
        logic b_rd;
        logic b_chk;
        logic d_init;
        logic d_top;
        logic d_rd;
        logic d_eval;
        logic d_push;
        logic d_pop;
    } t_cmd;

    // Status back to controller.
    typedef struct packed {
        logic vclr_done;
        logic fifo_empty;
        logic link_nil;
        logic stack_empty;
        logic nb_new;
    } t_stat;

endpackage

### src/gbd_ctrl.sv
module gbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_func,
    input  logic          i_bad_a,
    input  logic          i_bad_b,
    input  logic          i_full,
    input  gbd_pkg::t_stat i_stat,
    output gbd_pkg::t_cmd  o_cmd,
    output logic          busy,
    output logic          o_emit_cur,
    output logic          o_emit_nb,
    output logic          o_emit_fixed,
    output logic [1:0]    o_fixed_status,
    output logic          o_lastflag
);
    import gbd_pkg::*;

    t_state r_state, n_state;
    t_func  r_func, n_func;
    logic [1:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FUNC_CLEAR;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_st    = r_st;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        o_emit_cur = 1'b0;
        o_emit_nb  = 1'b0;
        o_emit_fixed = 1'b0;
        o_fixed_status = r_st;
        o_lastflag = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = t_func'(i_func);
                    n_st = ST_OK;
                    case (t_func'(i_func))
                        FUNC_CLEAR: n_state = S_CLR;
                        FUNC_ADD: begin
                            if (i_bad_a || i_bad_b) begin
                                n_st = ST_RANGE; n_state = S_RESULT;
                            end else if (i_full) begin
                                n_st = ST_FULL; n_state = S_RESULT;
                            end else begin
                                n_state = S_ADD_A;
                            end
                        end
                        default: begin
                            if (i_bad_a) begin
                                n_st = ST_RANGE; n_state = S_RESULT;
                            end else begin
                                n_state = S_VCLR;
                            end
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_heads = 1'b1;
                n_state = S_RESULT;
            end
            S_ADD_A: begin
                o_cmd.prepend_a = 1'b1;
                n_state = S_ADD_B;
            end
            S_ADD_B: begin
                o_cmd.prepend_b = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_emit_fixed = 1'b1;
                o_lastflag = 1'b1;
                n_state = S_IDLE;
            end
            S_VCLR: begin
                o_cmd.vclr = 1'b1;
                if (i_stat.vclr_done) begin
                    if (r_func == FUNC_BFS) begin
                        o_cmd.b_init = 1'b1;
                        n_state = S_B_POP;
                    end else begin
                        o_cmd.d_init = 1'b1;
                        o_emit_cur = 1'b1;
                        n_state = S_D_TOP;
                    end
                end
            end
            S_B_POP: begin
                if (i_stat.fifo_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.b_pop = 1'b1;
                    o_emit_cur = 1'b1;
                    n_state = S_B_HEAD;
                end
            end
            S_B_HEAD: begin
                o_cmd.b_head = 1'b1;
                n_state = S_B_WALK;
            end
            S_B_WALK: begin
                if (i_stat.link_nil) begin
                    n_state = S_B_POP;
                end else begin
                    o_cmd.b_rd = 1'b1;
                    n_state = S_B_RD;
                end
            end
            S_B_RD: n_state = S_B_CHK;
            S_B_CHK: begin
                o_cmd.b_chk = 1'b1;
                n_state = S_B_WALK;
            end
            S_D_TOP: begin
                if (i_stat.stack_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.d_top = 1'b1;
                    n_state = S_D_CHK;
                end
            end
            S_D_CHK: begin
                if (i_stat.link_nil) begin
                    o_cmd.d_pop = 1'b1;
                    n_state = S_D_TOP;
                end else begin
                    o_cmd.d_rd = 1'b1;
                    n_state = S_D_RD;
                end
            end
            S_D_RD: n_state = S_D_EVAL;
            S_D_EVAL: begin
                o_cmd.d_eval = 1'b1;
                if (i_stat.nb_new) begin
                    o_emit_nb = 1'b1;
                    n_state = S_D_PUSH;
                end else begin
                    n_state = S_D_TOP;
                end
            end
            S_D_PUSH: begin
                o_cmd.d_push = 1'b1;
                n_state = S_D_TOP;
            end
            S_DONE: begin
                o_lastflag = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### src/gbd_dpath.sv
module gbd_dpath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ENTRIES  = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [5:0]            i_first_vertex,
    input  logic [5:0]            i_second_vertex,
    input  logic [6:0]            i_vertex_count,
    input  gbd_pkg::t_cmd         i_cmd,
    output gbd_pkg::t_stat        o_stat,
    output logic                  o_bad_a,
    output logic                  o_bad_b,
    output logic                  o_full,
    output logic [5:0]            o_cur,
    output logic [5:0]            o_nb
);
    import gbd_pkg::*;

    localparam int VI_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EI_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // Heads live in a memory; a valid bit per vertex marks a list that is not empty.
    logic [LINK_W-1:0] r_head [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_hv;
    logic [MAX_VERTICES-1:0] r_vis;
    logic [VERT_W-1:0] r_nbm [MAX_ENTRIES];
    logic [LINK_W-1:0] r_nxm [MAX_ENTRIES];
    logic [VERT_W-1:0] r_fifo [MAX_VERTICES];
    logic [LINK_W-1:0] r_stk [MAX_VERTICES];
    logic [LINK_W-1:0] r_used;
    logic [VERT_W-1:0] r_a, r_b;
    logic [CNT_W-1:0]  r_front, r_rear, r_sp;
    logic [LINK_W-1:0] r_p;
    logic [VERT_W-1:0] r_rd_nb;
    logic [LINK_W-1:0] r_rd_nx;
    logic [VERT_W-1:0] r_cur;
    logic [VI_W:0]     r_vcnt;

    logic [6:0] eff;
    logic nb_ok;
    logic [VI_W-1:0] sp_idx;

    assign eff = (i_vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : i_vertex_count;
    assign o_bad_a = {1'b0, i_first_vertex} >= eff;
    assign o_bad_b = {1'b0, i_second_vertex} >= eff;
    assign o_full  = (32'(r_used) + 32'd2) > 32'(MAX_ENTRIES);
    assign sp_idx  = VI_W'(r_sp - CNT_W'(1));
    assign nb_ok = (32'(r_rd_nb) < 32'(MAX_VERTICES)) && !r_vis[VI_W'(r_rd_nb)];

    assign o_stat.vclr_done   = (r_vcnt == (VI_W+1)'(MAX_VERTICES - 1));
    assign o_stat.fifo_empty  = (r_front == r_rear);
    assign o_stat.link_nil    = (32'(r_p) >= 32'(MAX_ENTRIES));
    assign o_stat.stack_empty = (r_sp == '0);
    assign o_stat.nb_new      = nb_ok && (32'(r_sp) < 32'(MAX_VERTICES));
    assign o_cur = r_cur;
    assign o_nb  = r_rd_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= '0;
            r_used <= '0;
            r_vis  <= '0;
            r_vcnt <= '0;
            r_front <= '0;
            r_rear <= '0;
            r_sp   <= '0;
        end else begin
            if (i_cmd.clr_heads) begin
                r_hv   <= '0;
                r_used <= '0;
            end
            if (i_cmd.prepend_a) begin
                r_hv[VI_W'(r_a)] <= 1'b1;
                r_used <= r_used + LINK_W'(1);
            end
            if (i_cmd.prepend_b) begin
                r_hv[VI_W'(r_b)] <= 1'b1;
                r_used <= r_used + LINK_W'(1);
            end
            if (i_cmd.vclr) begin
                // On the final clearing cycle only the start vertex is left marked.
                r_vis  <= (i_cmd.b_init || i_cmd.d_init) ?
                          (MAX_VERTICES'(1) << r_a) : '0;
                r_vcnt <= r_vcnt + (VI_W+1)'(1);
            end else begin
                r_vcnt <= '0;
            end
            if (i_cmd.b_init) begin
                r_front <= '0;
                r_rear  <= CNT_W'(1);
            end
            if (i_cmd.b_pop) r_front <= r_front + CNT_W'(1);
            if (i_cmd.b_chk) begin
                if (nb_ok && (32'(r_rear) < 32'(MAX_VERTICES))) begin
                    r_vis[VI_W'(r_rd_nb)] <= 1'b1;
                    r_rear <= r_rear + CNT_W'(1);
                end
            end
            if (i_cmd.d_init) r_sp <= CNT_W'(1);
            if (i_cmd.d_pop) r_sp <= r_sp - CNT_W'(1);
            if (i_cmd.d_eval && o_stat.nb_new) begin
                r_vis[VI_W'(r_rd_nb)] <= 1'b1;
                r_sp <= r_sp + CNT_W'(1);
            end
        end
    end

    // Payload registers and memories.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_first_vertex;
            r_b <= i_second_vertex;
            r_cur <= i_first_vertex;
        end
        if (i_cmd.prepend_a) begin
            r_head[VI_W'(r_a)] <= r_used;
            r_nbm[EI_W'(r_used)] <= r_b;
            r_nxm[EI_W'(r_used)] <= r_hv[VI_W'(r_a)] ? r_head[VI_W'(r_a)] : NIL_LINK;
        end
        if (i_cmd.prepend_b) begin
            r_head[VI_W'(r_b)] <= r_used;
            r_nbm[EI_W'(r_used)] <= r_a;
            r_nxm[EI_W'(r_used)] <= r_hv[VI_W'(r_b)] ? r_head[VI_W'(r_b)] : NIL_LINK;
        end
        if (i_cmd.b_init) r_fifo[0] <= r_a;
        if (i_cmd.b_pop) r_cur <= r_fifo[VI_W'(r_front)];
        if (i_cmd.b_head)
            r_p <= r_hv[VI_W'(r_cur)] ? r_head[VI_W'(r_cur)] : NIL_LINK;
        if (i_cmd.b_chk) r_p <= r_rd_nx;
        if (i_cmd.b_rd || i_cmd.d_rd) begin
            r_rd_nb <= r_nbm[EI_W'(r_p)];
            r_rd_nx <= r_nxm[EI_W'(r_p)];
        end
        if (i_cmd.b_chk && nb_ok && (32'(r_rear) < 32'(MAX_VERTICES)))
            r_fifo[VI_W'(r_rear)] <= r_rd_nb;
        if (i_cmd.d_init)
            r_stk[0] <= r_hv[VI_W'(r_a)] ? r_head[VI_W'(r_a)] : NIL_LINK;
        if (i_cmd.d_top) r_p <= r_stk[sp_idx];
        // The top entry advances to the next link before any push.
        if (i_cmd.d_eval) r_stk[sp_idx] <= r_rd_nx;
        if (i_cmd.d_push)
            r_stk[sp_idx] <= r_hv[VI_W'(r_rd_nb)] ? r_head[VI_W'(r_rd_nb)] : NIL_LINK;
    end
endmodule

### src/graph_bfs_dfs_engine_top.sv
// A run first clears the visited marks and then walks the adjacency lists by BFS or DFS.
// One item at a time; busy falls in the cycle that shows the last result. Results appear
// with o_valid for one cycle each; the receiver cannot stall. Synchronous active-low
// reset empties the graph and sets vertex_count to 64.
module graph_bfs_dfs_engine_top #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ENTRIES  = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [5:0] i_first_vertex,
    input  logic [5:0] i_second_vertex,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [5:0] o_visited_vertex,
    output logic       o_last,
    output logic [1:0] o_status
);
    import gbd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic bad_a, bad_b, full;
    logic emit_cur, emit_nb, emit_fixed, lastflag;
    logic [1:0] fixed_status;
    logic [5:0] cur, nb;
    logic [6:0] r_vcount;
    logic r_pend;
    logic [5:0] r_pend_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vcount <= 7'd64;
        else if (i_cfg_we) r_vcount <= i_cfg_wdata;
    end

    gbd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .i_func,
        .i_bad_a(bad_a), .i_bad_b(bad_b), .i_full(full),
        .i_stat(stat), .o_cmd(cmd), .busy,
        .o_emit_cur(emit_cur), .o_emit_nb(emit_nb), .o_emit_fixed(emit_fixed),
        .o_fixed_status(fixed_status), .o_lastflag(lastflag)
    );

    gbd_dpath #(.MAX_VERTICES(MAX_VERTICES), .MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
        .i_clk, .i_rst_n, .i_load(start && !busy),
        .i_first_vertex, .i_second_vertex, .i_vertex_count(r_vcount),
        .i_cmd(cmd), .o_stat(stat), .o_bad_a(bad_a), .o_bad_b(bad_b),
        .o_full(full), .o_cur(cur), .o_nb(nb)
    );

    // A traversal vertex is held back one emit so the final one can carry last.
    // In BFS the popped vertex appears in cur in the cycle after the pop command.
    logic r_cur_due;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_cur_due <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid   <= 1'b0;
            r_cur_due <= emit_cur;
            if (emit_fixed) begin
                o_valid <= 1'b1;
                o_visited_vertex <= '0;
                o_last <= 1'b1;
                o_status <= fixed_status;
            end else if (lastflag) begin
                o_valid <= r_pend;
                o_visited_vertex <= r_pend_v;
                o_last <= 1'b1;
                o_status <= ST_OK;
                r_pend <= 1'b0;
            end else if (r_cur_due || emit_nb) begin
                o_valid <= r_pend;
                o_visited_vertex <= r_pend_v;
                o_last <= 1'b0;
                o_status <= ST_OK;
                r_pend <= 1'b1;
                r_pend_v <= r_cur_due ? cur : nb;
            end
        end
    end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import gbd_pkg::*;

    localparam int NV = 64;
    localparam int NE = 512;

    typedef struct packed {
        logic [5:0] vertex;
        logic       last;
        logic [1:0] status;
    } t_visit;

    // Scoreboard: holds its own copy of the graph and predicts the visit sequence.
    class traversal_board;
        logic [9:0] head[NV];
        logic [5:0] nbr[NE];
        logic [9:0] link[NE];
        int unsigned used;
        logic [6:0] vcount;
        bit         marked[NV];
        t_visit     pending[$];
        int         errors;

        function void wipe();
            foreach (head[i]) head[i] = NIL_LINK;
            used = 0;
        endfunction

        function void link_in(int owner, logic [5:0] nb);
            nbr[used] = nb;
            link[used] = head[owner];
            head[owner] = used[9:0];
            used++;
        endfunction

        function void push(logic [5:0] v, t_status st);
            t_visit r;
            r.vertex = v;
            r.last = 1'b0;
            r.status = st;
            pending.push_back(r);
        endfunction

        function void close_item();
            t_visit r;
            r = pending.pop_back();
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        function void note_item(t_func f, logic [5:0] a, logic [5:0] b);
            int cnt;
            int lo, hi, sp;
            int p;
            int q[NV];
            int stk[NV];
            cnt = (vcount > NV) ? NV : vcount;
            if (f == FUNC_CLEAR) begin
                wipe();
                push(0, ST_OK);
            end else if (f == FUNC_ADD) begin
                if (a >= cnt || b >= cnt) begin
                    push(0, ST_RANGE);
                end else if (used + 2 > NE) begin
                    push(0, ST_FULL);
                end else begin
                    link_in(a, b);
                    link_in(b, a);
                    push(0, ST_OK);
                end
            end else if (a >= cnt) begin
                push(0, ST_RANGE);
            end else begin
                foreach (marked[i]) marked[i] = 0;
                marked[a] = 1;
                if (f == FUNC_BFS) begin
                    lo = 0;
                    hi = 1;
                    q[0] = a;
                    while (lo < hi) begin
                        push(q[lo][5:0], ST_OK);
                        p = head[q[lo]];
                        lo++;
                        while (p < NE) begin
                            if (!marked[nbr[p]] && hi < NV) begin
                                marked[nbr[p]] = 1;
                                q[hi] = nbr[p];
                                hi++;
                            end
                            p = link[p];
                        end
                    end
                end else begin
                    push(a, ST_OK);
                    sp = 1;
                    stk[0] = head[a];
                    while (sp > 0) begin
                        p = stk[sp-1];
                        if (p >= NE) begin
                            sp--;
                        end else begin
                            stk[sp-1] = link[p];
                            if (!marked[nbr[p]] && sp < NV) begin
                                marked[nbr[p]] = 1;
                                push(nbr[p], ST_OK);
                                stk[sp] = head[nbr[p]];
                                sp++;
                            end
                        end
                    end
                end
            end
            close_item();
        endfunction

        function void check_result(logic [5:0] v, logic l, logic [1:0] st);
            t_visit e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: vertex %0d last %0d status %0d", v, l, st);
                return;
            end
            e = pending.pop_front();
            if (e.vertex !== v || e.last !== l || e.status !== st) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected v%0d l%0d s%0d, got v%0d l%0d s%0d",
                             e.vertex, e.last, e.status, v, l, st);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic [5:0] i_first_vertex;
    logic [5:0] i_second_vertex;
    logic       i_cfg_we;
    logic [6:0] i_cfg_wdata;
    logic       o_valid;
    logic [5:0] o_visited_vertex;
    logic       o_last;
    logic [1:0] o_status;

    traversal_board board;
    int idle_pct;

    graph_bfs_dfs_engine_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_visited_vertex(o_visited_vertex),
        .o_last          (o_last),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_visited_vertex, o_last, o_status);
    end

    // Holds start high until the item is taken at a rising edge with busy low.
    // Start goes low again between items, while busy is high anyway.
    task automatic send_item(t_func f, logic [5:0] a, logic [5:0] b);
        bit taken;
        @(negedge i_clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            @(negedge i_clk);
        start <= 1'b1;
        i_func <= f;
        i_first_vertex <= a;
        i_second_vertex <= b;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        board.note_item(f, a, b);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_count(logic [6:0] n);
        while (board.pending.size() != 0 || busy)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.vcount = n;
    endtask

    task automatic random_items(int n, int cnt);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom));
            else if (r < 60)
                send_item(FUNC_ADD, 6'($urandom_range(cnt - 1)), 6'($urandom_range(cnt - 1)));
            else if (r < 68)
                send_item(FUNC_ADD, 6'($urandom), 6'($urandom));
            else if (r < 82)
                send_item(FUNC_BFS, 6'((r < 80) ? $urandom_range(cnt - 1) : $urandom),
                          6'($urandom));
            else
                send_item(FUNC_DFS, 6'((r < 97) ? $urandom_range(cnt - 1) : $urandom),
                          6'($urandom));
        end
    endtask

    // Mostly edges between any vertices, with a run now and then over the growing graph.
    task automatic fill_items(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if (k % 64 == 63)
                send_item(FUNC_DFS, 6'($urandom), 6'($urandom));
            else if (k % 32 == 31)
                send_item(FUNC_BFS, 6'($urandom), 6'($urandom));
            else
                send_item(FUNC_ADD, 6'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        int k;
        board = new();
        board.wipe();
        board.vcount = 7'd64;
        board.errors = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_CLEAR;
        i_first_vertex = '0;
        i_second_vertex = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, self loop, bad starts, lists newest first.
        send_item(FUNC_BFS, 6'd0, 6'd0);
        send_item(FUNC_DFS, 6'd63, 6'd63);
        send_item(FUNC_ADD, 6'd0, 6'd63);
        send_item(FUNC_ADD, 6'd0, 6'd1);
        send_item(FUNC_ADD, 6'd1, 6'd2);
        send_item(FUNC_ADD, 6'd5, 6'd5);
        send_item(FUNC_ADD, 6'd2, 6'd63);
        send_item(FUNC_BFS, 6'd0, 6'd42);
        send_item(FUNC_DFS, 6'd0, 6'd21);
        send_item(FUNC_DFS, 6'd5, 6'd0);
        send_item(FUNC_CLEAR, 6'd63, 6'd63);
        send_item(FUNC_BFS, 6'd63, 6'd0);
        set_count(7'd1);
        send_item(FUNC_ADD, 6'd0, 6'd0);
        send_item(FUNC_ADD, 6'd0, 6'd1);
        send_item(FUNC_BFS, 6'd1, 6'd0);
        send_item(FUNC_DFS, 6'd0, 6'd0);
        set_count(7'd0);
        send_item(FUNC_ADD, 6'd0, 6'd0);
        send_item(FUNC_DFS, 6'd0, 6'd0);
        set_count(7'd127);
        // A chain through all vertices, then fill the store to the brim.
        for (k = 0; k < 63; k++)
            send_item(FUNC_ADD, k[5:0], k[5:0] + 6'd1);
        send_item(FUNC_DFS, 6'd0, 6'd0);
        send_item(FUNC_BFS, 6'd32, 6'd0);
        idle_pct = 87;
        fill_items(67);
        idle_pct = 22;
        fill_items(67);
        idle_pct = 0;
        fill_items(66);
        send_item(FUNC_ADD, 6'd3, 6'd4);
        send_item(FUNC_BFS, 6'd7, 6'd0);
        send_item(FUNC_DFS, 6'd9, 6'd0);
        send_item(FUNC_CLEAR, 6'd0, 6'd0);

        // A short random phase on a small graph, then bad starts at a low count.
        set_count(7'd12);
        random_items(12, 12);
        set_count(7'd3);
        send_item(FUNC_BFS, 6'd30, 6'd0);
        send_item(FUNC_DFS, 6'd30, 6'd0);

        while (board.pending.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
